// ===== design/assert_macros.svh =====
// Shared assertion forms; the enclosing module provides clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== design/licc_pkg.sv =====
`default_nettype none
package licc_pkg;

	localparam int SIZE_BITS  = 11;
	localparam int QUO_BITS   = 10;
	localparam int IDX_BITS   = 30;
	localparam int PLANE_BITS = 21;
	localparam int NODE_BITS  = 31;
	localparam int REG_IDX_BITS = 2;
	localparam logic [SIZE_BITS-1:0] SIZE_MAX = 11'd1024;
	localparam logic [SIZE_BITS-1:0] SIZE_MIN = 11'd1;

	typedef enum logic {
		CMD_TO_INDEX = 1'b0,
		CMD_TO_COORD = 1'b1
	} cmd_t;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_SIZE_X = 2'd0,
		REG_SIZE_Y = 2'd1,
		REG_SIZE_Z = 2'd2
	} reg_idx_t;

	// Lattice geometry as seen by the datapath
	typedef struct packed {
		logic [SIZE_BITS-1:0]  size_x;
		logic [SIZE_BITS-1:0]  size_y;
		logic [SIZE_BITS-1:0]  size_z;
		logic [PLANE_BITS-1:0] plane;
		logic [NODE_BITS-1:0]  node;
		logic                  busy;
	} geom_t;

	// Fields that ride along with the divider pipeline
	typedef struct packed {
		logic                cmd;
		logic                err;
		logic [IDX_BITS-1:0] idx;
	} side_t;

	// Sizes are held in 1..1024
	function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] v);
		logic [SIZE_BITS-1:0] r;
		r = v;
		if (v == '0) r = SIZE_MIN;
		else if (v > SIZE_MAX) r = SIZE_MAX;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/licc_ifs.sv =====
`default_nettype none
// Request channel
interface licc_in_if #(parameter int COORD_BITS = 10);
	logic                  valid;
	logic                  ready;
	logic                  cmd;
	logic [COORD_BITS-1:0] coord_x;
	logic [COORD_BITS-1:0] coord_y;
	logic [COORD_BITS-1:0] coord_z;
	logic [29:0]           node_index;

	modport source (output valid, cmd, coord_x, coord_y, coord_z, node_index, input ready);
	modport sink (input valid, cmd, coord_x, coord_y, coord_z, node_index, output ready);
endinterface

// Result channel
interface licc_out_if #(parameter int COORD_BITS = 10);
	logic                  valid;
	logic                  ready;
	logic [29:0]           out_index;
	logic [COORD_BITS-1:0] out_x;
	logic [COORD_BITS-1:0] out_y;
	logic [COORD_BITS-1:0] out_z;
	logic                  range_error;

	modport source (output valid, out_index, out_x, out_y, out_z, range_error, input ready);
	modport sink (input valid, out_index, out_x, out_y, out_z, range_error, output ready);
endinterface
`default_nettype wire

// ===== design/licc_cfg.sv =====
`default_nettype none
`include "assert_macros.svh"
module licc_cfg
	import licc_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    wr_en,
	input  wire logic [REG_IDX_BITS-1:0] wr_idx,
	input  wire logic [SIZE_BITS-1:0]    wr_data,
	output geom_t                        geom
);

	logic [SIZE_BITS-1:0]  size_x_q, size_y_q, size_z_q;
	logic [PLANE_BITS-1:0] plane_q;
	logic [NODE_BITS-1:0]  node_q;
	logic [1:0]            busy_q;
	logic                  hit;

	assign hit = wr_en && (wr_idx == REG_SIZE_X || wr_idx == REG_SIZE_Y || wr_idx == REG_SIZE_Z);

	// Size registers, clamped on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_MIN;
			size_y_q <= SIZE_MIN;
			size_z_q <= SIZE_MIN;
		end else if (wr_en) begin
			case (wr_idx)
				REG_SIZE_X: size_x_q <= clamp_size(wr_data);
				REG_SIZE_Y: size_y_q <= clamp_size(wr_data);
				REG_SIZE_Z: size_z_q <= clamp_size(wr_data);
				default: ;
			endcase
		end
	end

	// Derived sizes: plane registered from the size registers, node count registered from plane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= PLANE_BITS'(1);
			node_q  <= NODE_BITS'(1);
			busy_q  <= '0;
		end else begin
			plane_q <= PLANE_BITS'(size_x_q * size_y_q);
			node_q  <= NODE_BITS'(plane_q * size_z_q);
			busy_q  <= hit ? 2'b11 : {1'b0, busy_q[1]};
		end
	end

	assign geom = '{size_x: size_x_q, size_y: size_y_q, size_z: size_z_q,
		plane: plane_q, node: node_q, busy: |busy_q};

	`ASSERT_NEXT(a_busy_after_write, hit, geom.busy, "no hold-off after size write")
	`ASSERT_CLK(a_plane_settled, !geom.busy |-> plane_q == PLANE_BITS'(size_x_q * size_y_q),
		"plane size stale while idle")

endmodule
`default_nettype wire

// ===== design/licc_div.sv =====
`default_nettype none
module licc_div #(
	parameter int NUM_W  = 30,
	parameter int DEN_W  = 21,
	parameter int Q_BITS = 10,
	parameter int SB_W   = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [NUM_W-1:0]  in_num,
	input  wire logic [DEN_W-1:0]  den,
	input  wire logic [SB_W-1:0]   in_sb,
	output logic                   out_valid,
	output logic [Q_BITS-1:0]      out_q,
	output logic [NUM_W-1:0]       out_rem,
	output logic [SB_W-1:0]        out_sb
);

	localparam int CW = (NUM_W > DEN_W + Q_BITS - 1) ? NUM_W : DEN_W + Q_BITS - 1;

	logic              vld_s [Q_BITS];
	logic [NUM_W-1:0]  rem_s [Q_BITS];
	logic [Q_BITS-1:0] quo_s [Q_BITS];
	logic [SB_W-1:0]   sb_s  [Q_BITS];

	// One restoring step per stage, quotient MSB first
	for (genvar i = 0; i < Q_BITS; i++) begin : g_step
		logic              pv;
		logic [NUM_W-1:0]  prem;
		logic [Q_BITS-1:0] pq;
		logic [SB_W-1:0]   psb;
		logic [CW-1:0]     trial;
		logic              take;

		if (i == 0) begin : g_first
			assign pv   = in_valid;
			assign prem = in_num;
			assign pq   = '0;
			assign psb  = in_sb;
		end else begin : g_next
			assign pv   = vld_s[i-1];
			assign prem = rem_s[i-1];
			assign pq   = quo_s[i-1];
			assign psb  = sb_s[i-1];
		end

		assign trial = CW'(den) << (Q_BITS - 1 - i);
		assign take  = CW'(prem) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[i] <= 1'b0;
			else if (en) vld_s[i] <= pv;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= take ? NUM_W'(CW'(prem) - trial) : prem;
				quo_s[i] <= pq | (take ? (Q_BITS'(1) << (Q_BITS - 1 - i)) : '0);
				sb_s[i]  <= psb;
			end
		end
	end

	assign out_valid = vld_s[Q_BITS-1];
	assign out_q     = quo_s[Q_BITS-1];
	assign out_rem   = rem_s[Q_BITS-1];
	assign out_sb    = sb_s[Q_BITS-1];

endmodule
`default_nettype wire

// ===== design/lattice_index_coord_convert.sv =====
// Lattice index converter: coordinates <-> x-fastest node number.
// Request channel in_ch: cmd 0 converts (coord_x, coord_y, coord_z) to a node
// number, cmd 1 converts node_index back to coordinates. Result channel out_ch
// gives one result per request; out-of-lattice requests give range_error with
// all other fields zero. Sizes are written on wr_en/wr_idx/wr_data (0 = x,
// 1 = y, 2 = z) and clamped to 1..1024; the user must write them only while no
// request is in flight, which the block itself does not enforce. Throughput:
// one transfer per cycle while neither a stall nor a size update holds it.
// Pipeline: 24 register stages (capture, multiply, add, two 10-stage restoring
// dividers of one quotient bit per stage, output register). After a size write,
// in_ch.ready stays low while plane size and node count are recomputed through
// their multipliers. Reset sets all sizes to 1 and empties the pipeline. When
// out_ch.ready is low with a result held, the whole pipeline holds and
// in_ch.ready drops; nothing is lost or repeated.
`default_nettype none
`include "assert_macros.svh"
module lattice_index_coord_convert
	import licc_pkg::*;
#(
	parameter int COORD_BITS = 10
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    wr_en,
	input  wire logic [REG_IDX_BITS-1:0] wr_idx,
	input  wire logic [SIZE_BITS-1:0]    wr_data,
	licc_in_if.sink                      in_ch,
	licc_out_if.source                   out_ch
);

	localparam int CW = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
	localparam int PY_BITS = QUO_BITS + SIZE_BITS - 1;
	localparam int SB_W = $bits(side_t);
	localparam int SB2_W = SB_W + QUO_BITS;
	localparam int REM2_W = PLANE_BITS - 1;

	geom_t geom;
	logic  en;

	licc_cfg u_cfg (
		.clk, .arst_n, .wr_en, .wr_idx, .wr_data, .geom
	);

	logic out_valid_q;
	assign en = !out_valid_q || out_ch.ready;
	assign in_ch.ready = en && !geom.busy;

	// Bounds check on the incoming request
	logic [CW-1:0] cx, cy, cz;
	logic          in_err;
	assign cx = CW'(in_ch.coord_x);
	assign cy = CW'(in_ch.coord_y);
	assign cz = CW'(in_ch.coord_z);
	always_comb begin
		if (in_ch.cmd == CMD_TO_INDEX)
			in_err = (cx >= CW'(geom.size_x)) || (cy >= CW'(geom.size_y)) ||
				(cz >= CW'(geom.size_z));
		else
			in_err = {1'b0, in_ch.node_index} >= geom.node;
	end

	// Stage 1: capture
	logic                v_s1, cmd_s1, err_s1;
	logic [QUO_BITS-1:0] x_s1, y_s1, z_s1;
	logic [IDX_BITS-1:0] n_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_ch.valid && !geom.busy;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= in_ch.cmd;
			err_s1 <= in_err;
			x_s1   <= cx[QUO_BITS-1:0];
			y_s1   <= cy[QUO_BITS-1:0];
			z_s1   <= cz[QUO_BITS-1:0];
			n_s1   <= in_ch.node_index;
		end
	end

	// Stage 2: plane and row products
	logic                v_s2, cmd_s2, err_s2;
	logic [QUO_BITS-1:0] x_s2;
	logic [IDX_BITS-1:0] pz_s2, n_s2;
	logic [PY_BITS-1:0]  py_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2 <= cmd_s1;
			err_s2 <= err_s1;
			x_s2   <= x_s1;
			pz_s2  <= IDX_BITS'(z_s1 * geom.plane);
			py_s2  <= PY_BITS'(y_s1 * geom.size_x);
			n_s2   <= n_s1;
		end
	end

	// Stage 3: index sum
	logic                v_s3;
	side_t               sb_s3;
	logic [IDX_BITS-1:0] n_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sb_s3.cmd <= cmd_s2;
			sb_s3.err <= err_s2;
			sb_s3.idx <= pz_s2 + IDX_BITS'(py_s2) + IDX_BITS'(x_s2);
			n_s3      <= n_s2;
		end
	end

	// z = n / plane, remainder on to the second divider
	logic                d1_valid;
	logic [QUO_BITS-1:0] d1_q;
	logic [IDX_BITS-1:0] d1_rem;
	logic [SB_W-1:0]     d1_sb;
	licc_div #(.NUM_W(IDX_BITS), .DEN_W(PLANE_BITS), .Q_BITS(QUO_BITS), .SB_W(SB_W)) u_div_z (
		.clk, .arst_n, .en,
		.in_valid(v_s3), .in_num(n_s3), .den(geom.plane), .in_sb(sb_s3),
		.out_valid(d1_valid), .out_q(d1_q), .out_rem(d1_rem), .out_sb(d1_sb)
	);

	// y = rem / size_x, x = rem % size_x
	logic                d2_valid;
	logic [QUO_BITS-1:0] d2_q;
	logic [REM2_W-1:0]   d2_rem;
	logic [SB2_W-1:0]    d2_sb;
	side_t               sb_f;
	logic [QUO_BITS-1:0] z_f;
	licc_div #(.NUM_W(REM2_W), .DEN_W(SIZE_BITS), .Q_BITS(QUO_BITS), .SB_W(SB2_W)) u_div_y (
		.clk, .arst_n, .en,
		.in_valid(d1_valid), .in_num(d1_rem[REM2_W-1:0]), .den(geom.size_x),
		.in_sb({d1_sb, d1_q}),
		.out_valid(d2_valid), .out_q(d2_q), .out_rem(d2_rem), .out_sb(d2_sb)
	);
	assign {sb_f, z_f} = d2_sb;

	// Output register
	logic                  err_q;
	logic [IDX_BITS-1:0]   idx_q;
	logic [COORD_BITS-1:0] ox_q, oy_q, oz_q;
	logic                  idx_ok, crd_ok;
	assign idx_ok = !sb_f.err && sb_f.cmd == CMD_TO_INDEX;
	assign crd_ok = !sb_f.err && sb_f.cmd == CMD_TO_COORD;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= d2_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			err_q <= sb_f.err;
			idx_q <= idx_ok ? sb_f.idx : '0;
			ox_q  <= crd_ok ? COORD_BITS'(d2_rem[QUO_BITS-1:0]) : '0;
			oy_q  <= crd_ok ? COORD_BITS'(d2_q) : '0;
			oz_q  <= crd_ok ? COORD_BITS'(z_f) : '0;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.out_index   = idx_q;
	assign out_ch.out_x       = ox_q;
	assign out_ch.out_y       = oy_q;
	assign out_ch.out_z       = oz_q;
	assign out_ch.range_error = err_q;

	`ASSERT_CLK(a_err_zero, out_ch.valid && out_ch.range_error |->
		out_ch.out_index == '0 && out_ch.out_x == '0 && out_ch.out_y == '0 &&
		out_ch.out_z == '0, "range error with nonzero result")
	`ASSERT_CLK(a_hold_when_busy, geom.busy |-> !in_ch.ready, "request taken during size update")
	`ASSERT_NEXT(a_stall_holds, out_ch.valid && !out_ch.ready, out_ch.valid,
		"result dropped under stall")

endmodule
`default_nettype wire

// ===== verif/tb_lattice_index_coord_convert.sv =====
`default_nettype none
module tb_lattice_index_coord_convert;
	import licc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = 10;
	localparam int LATENCY = 24;
	localparam int N_RANDOM = 1630;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [REG_IDX_BITS-1:0] wr_idx;
	logic [SIZE_BITS-1:0] wr_data;

	licc_in_if #(.COORD_BITS(CB)) req_ch ();
	licc_out_if #(.COORD_BITS(CB)) res_ch ();

	lattice_index_coord_convert #(.COORD_BITS(CB)) dut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data),
		.in_ch(req_ch.sink), .out_ch(res_ch.source)
	);

	typedef struct packed {
		cmd_t            cmd;
		logic [CB-1:0]   x;
		logic [CB-1:0]   y;
		logic [CB-1:0]   z;
		logic [29:0]     node;
	} request_t;

	typedef struct packed {
		logic [29:0]   index;
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		logic [CB-1:0] z;
		logic          err;
	} answer_t;

	// Local copy of the lattice geometry
	logic [SIZE_BITS-1:0] ext_x, ext_y, ext_z;
	logic [31:0] plane_nodes, total_nodes;

	answer_t pending_answers[$];
	int n_errors;
	int n_results;
	int n_oob;
	int n_to_coord;
	bit stim_done;

	// Stimulus table: request plus, where obvious, the typed-in answer
	typedef struct {
		request_t req;
		bit       known;
		answer_t  ans;
	} vector_t;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("timeout: %0d answers outstanding", pending_answers.size());
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [SIZE_BITS-1:0] held_size(input logic [SIZE_BITS-1:0] v);
		if (v == 0) return 1;
		if (v > 1024) return 1024;
		return v;
	endfunction

	function automatic answer_t convert(input request_t r);
		answer_t a;
		logic [31:0] rem;
		a = '0;
		if (r.cmd == CMD_TO_INDEX) begin
			if (r.x >= ext_x || r.y >= ext_y || r.z >= ext_z) a.err = 1'b1;
			else a.index = 30'(r.z * plane_nodes + r.y * ext_x + r.x);
		end else begin
			if (r.node >= total_nodes) a.err = 1'b1;
			else begin
				rem = r.node % plane_nodes;
				a.z = CB'(r.node / plane_nodes);
				a.y = CB'(rem / ext_x);
				a.x = CB'(rem % ext_x);
			end
		end
		return a;
	endfunction

	task automatic report(input string what);
		n_errors++;
		$display("mismatch @%0t: %s", $realtime, what);
	endtask

	// Size register write; model tracks the held value
	task automatic write_size(input reg_idx_t r, input logic [SIZE_BITS-1:0] v);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_idx <= r;
		wr_data <= v;
		@(negedge clk);
		wr_en <= 1'b0;
		case (r)
			REG_SIZE_X: ext_x = held_size(v);
			REG_SIZE_Y: ext_y = held_size(v);
			default: ext_z = held_size(v);
		endcase
		plane_nodes = ext_x * ext_y;
		total_nodes = plane_nodes * ext_z;
	endtask

	task automatic set_box(input logic [SIZE_BITS-1:0] sx, sy, sz);
		write_size(REG_SIZE_X, sx);
		write_size(REG_SIZE_Y, sy);
		write_size(REG_SIZE_Z, sz);
	endtask

	// Send one request; expected answer is queued at the transfer.
	// valid stays up after the transfer until the next falling edge,
	// where it either drops for the gap or carries the next request.
	task automatic send(input request_t r, input bit known, input answer_t typed);
		int gap;
		answer_t a;
		gap = $urandom_range(0, 9);
		if ($urandom_range(0, 3) == 0) gap = 0;
		@(negedge clk);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= r.cmd;
		req_ch.coord_x <= r.x;
		req_ch.coord_y <= r.y;
		req_ch.coord_z <= r.z;
		req_ch.node_index <= r.node;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		a = convert(r);
		if (known && a != typed) report("typed answer disagrees with predictor");
		pending_answers.push_back(known ? typed : a);
		if (r.cmd == CMD_TO_COORD) n_to_coord++;
		if (a.err) n_oob++;
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_answers.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic request_t random_request();
		request_t r;
		r.cmd = cmd_t'($urandom_range(0, 1));
		r.x = CB'($urandom);
		r.y = CB'($urandom);
		r.z = CB'($urandom);
		r.node = 30'($urandom);
		// mostly in range, some just over the edge, rest anywhere
		case ($urandom_range(0, 9))
			0, 1: ;
			2: begin
				r.x = CB'(ext_x - 1 + $urandom_range(0, 1));
				r.y = CB'(ext_y - 1 + $urandom_range(0, 1));
				r.z = CB'(ext_z - 1 + $urandom_range(0, 1));
				r.node = 30'(total_nodes - 1 + $urandom_range(0, 1));
			end
			default: begin
				r.x = CB'($urandom_range(0, ext_x - 1));
				r.y = CB'($urandom_range(0, ext_y - 1));
				r.z = CB'($urandom_range(0, ext_z - 1));
				r.node = 30'($urandom_range(0, total_nodes - 1));
			end
		endcase
		return r;
	endfunction

	// Result side: random stalls, compare each transfer with oldest answer
	initial begin
		int stall;
		answer_t want;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = stim_done ? 0 : $urandom_range(0, 9);
			if ($urandom_range(0, 3) == 0) stall = 0;
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
			n_results++;
			if (pending_answers.size() == 0) report("result with nothing expected");
			else begin
				want = pending_answers.pop_front();
				if (res_ch.out_index !== want.index)
					report($sformatf("out_index %0d, want %0d", res_ch.out_index, want.index));
				if (res_ch.out_x !== want.x)
					report($sformatf("out_x %0d, want %0d", res_ch.out_x, want.x));
				if (res_ch.out_y !== want.y)
					report($sformatf("out_y %0d, want %0d", res_ch.out_y, want.y));
				if (res_ch.out_z !== want.z)
					report($sformatf("out_z %0d, want %0d", res_ch.out_z, want.z));
				if (res_ch.range_error !== want.err)
					report($sformatf("range_error %0b, want %0b", res_ch.range_error, want.err));
			end
		end
	end

	// Main sequence
	initial begin
		vector_t vectors[$];
		vector_t v;
		logic [SIZE_BITS-1:0] sx, sy, sz;
		int phase;
		n_errors = 0;
		n_results = 0;
		n_oob = 0;
		n_to_coord = 0;
		stim_done = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_idx = REG_SIZE_X;
		wr_data = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_TO_INDEX;
		req_ch.coord_x = '0;
		req_ch.coord_y = '0;
		req_ch.coord_z = '0;
		req_ch.node_index = '0;
		ext_x = 1;
		ext_y = 1;
		ext_z = 1;
		plane_nodes = 1;
		total_nodes = 1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// 1x1x1 box after reset: only the origin is inside
		v = '{'{CMD_TO_INDEX, 10'd0, 10'd0, 10'd0, 30'h3FFFFFFF}, 1, '0};
		vectors.push_back(v);
		v = '{'{CMD_TO_COORD, 10'h3FF, 10'h3FF, 10'h3FF, 30'd0}, 1, '0};
		vectors.push_back(v);
		v = '{'{CMD_TO_INDEX, 10'd1, 10'd0, 10'd0, 30'd0}, 1, '{0, 0, 0, 0, 1}};
		vectors.push_back(v);
		v = '{'{CMD_TO_COORD, 10'd0, 10'd0, 10'd0, 30'd1}, 1, '{0, 0, 0, 0, 1}};
		vectors.push_back(v);
		v = '{'{CMD_TO_COORD, 10'd0, 10'd0, 10'd0, 30'h3FFFFFFF}, 1, '{0, 0, 0, 0, 1}};
		vectors.push_back(v);
		foreach (vectors[i]) send(vectors[i].req, vectors[i].known, vectors[i].ans);
		drain();

		// Full 1024^3 box: size writes above 1024 clamp to 1024
		set_box(11'd2047, 11'd1025, 11'd1024);
		vectors.delete();
		v = '{'{CMD_TO_INDEX, 10'h3FF, 10'h3FF, 10'h3FF, 30'd0}, 1,
			'{30'h3FFFFFFF, 0, 0, 0, 0}};
		vectors.push_back(v);
		v = '{'{CMD_TO_COORD, 10'd0, 10'd0, 10'd0, 30'h3FFFFFFF}, 1,
			'{0, 10'h3FF, 10'h3FF, 10'h3FF, 0}};
		vectors.push_back(v);
		v = '{'{CMD_TO_COORD, 10'd0, 10'd0, 10'd0, 30'd0}, 1, '0};
		vectors.push_back(v);
		v = '{'{CMD_TO_INDEX, 10'h2AA, 10'h155, 10'h2AA, 30'h15555555}, 0, '0};
		vectors.push_back(v);
		v = '{'{CMD_TO_COORD, 10'h155, 10'h2AA, 10'h155, 30'h2AAAAAAA}, 0, '0};
		vectors.push_back(v);
		foreach (vectors[i]) send(vectors[i].req, vectors[i].known, vectors[i].ans);
		drain();

		// Zero writes clamp to 1; then an odd-shaped box
		set_box(11'd0, 11'd0, 11'd0);
		send('{CMD_TO_INDEX, 10'd0, 10'd0, 10'd1, 30'd0}, 1, '{0, 0, 0, 0, 1});
		drain();
		set_box(11'd7, 11'd3, 11'd5);
		vectors.delete();
		v = '{'{CMD_TO_INDEX, 10'd6, 10'd2, 10'd4, 30'd0}, 1, '{30'd104, 0, 0, 0, 0}};
		vectors.push_back(v);
		v = '{'{CMD_TO_COORD, 10'd0, 10'd0, 10'd0, 30'd104}, 1, '{0, 10'd6, 10'd2, 10'd4, 0}};
		vectors.push_back(v);
		v = '{'{CMD_TO_COORD, 10'd0, 10'd0, 10'd0, 30'd105}, 1, '{0, 0, 0, 0, 1}};
		vectors.push_back(v);
		v = '{'{CMD_TO_INDEX, 10'd7, 10'd0, 10'd0, 30'd0}, 1, '{0, 0, 0, 0, 1}};
		vectors.push_back(v);
		v = '{'{CMD_TO_INDEX, 10'd0, 10'd3, 10'd0, 30'd0}, 1, '{0, 0, 0, 0, 1}};
		vectors.push_back(v);
		v = '{'{CMD_TO_INDEX, 10'd0, 10'd0, 10'd5, 30'd0}, 1, '{0, 0, 0, 0, 1}};
		vectors.push_back(v);
		v = '{'{CMD_TO_INDEX, 10'd3, 10'd1, 10'd2, 30'd0}, 0, '0};
		vectors.push_back(v);
		foreach (vectors[i]) send(vectors[i].req, vectors[i].known, vectors[i].ans);
		drain();

		// Random phases, each with a fresh box; last phase back to extremes
		for (phase = 0; phase < 10; phase++) begin
			case ($urandom_range(0, 3))
				0: begin sx = $urandom_range(1, 16); sy = $urandom_range(1, 16);
					sz = $urandom_range(1, 16); end
				1: begin sx = $urandom_range(1, 1024); sy = $urandom_range(1, 1024);
					sz = $urandom_range(1, 1024); end
				2: begin sx = $urandom; sy = $urandom; sz = $urandom; end
				default: begin sx = 11'd1024; sy = $urandom_range(1, 3);
					sz = 11'd1024; end
			endcase
			if (phase == 9) begin sx = 11'd1024; sy = 11'd1024; sz = 11'd1024; end
			set_box(sx, sy, sz);
			repeat (N_RANDOM / 10) send(random_request(), 0, '0);
			drain();
		end

		stim_done = 1'b1;
		drain();
		$display("%0d results checked, %0d to coordinates, %0d out of range",
			n_results, n_to_coord, n_oob);
		$display("boxes from 1x1x1 to 1024^3 with clamped size writes; stalls on both sides");
		if (n_errors == 0 && pending_answers.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/licc_pkg.sv
design/licc_ifs.sv
design/licc_cfg.sv
design/licc_div.sv
design/lattice_index_coord_convert.sv
verif/tb_lattice_index_coord_convert.sv
